>>> rtl/tqm_pkg.sv
`default_nettype none
package tqm_pkg;

	localparam int MAX_TIMERS_DEF = 32;
	localparam int ID_WIDTH_DEF   = 16;
	localparam int TIME_WIDTH_DEF = 48;

	localparam logic signed [31:0] WAIT_NONE = -32'sd1;
	localparam logic [31:0]        WAIT_MAX  = 32'h7FFF_FFFF;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_DEL  = 2'd1,
		OP_TICK = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_ADDED     = 3'd0,
		KIND_FULL      = 3'd1,
		KIND_DELETED   = 3'd2,
		KIND_NOT_FOUND = 3'd3,
		KIND_EXPIRED   = 3'd4,
		KIND_TICK_DONE = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		SCAN_DUE = 2'd0,
		SCAN_ALL = 2'd1,
		SCAN_ID  = 2'd2
	} scan_mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_ADD,
		ST_SCAN,
		ST_DEL,
		ST_DUE,
		ST_REM,
		ST_PER,
		ST_ONE,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [30:0] delay_ms;
		logic        periodic;
		logic [15:0] target_id;
		logic [15:0] elapsed_ms;
	} tqm_in_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [15:0]        tmr_id;
		logic               is_periodic;
		logic signed [31:0] next_wait;
		logic               last;
	} tqm_out_t;

	// controller -> datapath
	typedef struct packed {
		logic       item_load;
		logic       now_adv;
		logic       scan_start;
		logic       scan_step;
		scan_mode_t scan_mode;
		logic       rem_start;
		logic       rem_step;
		logic       add_commit;
		logic       del_commit;
		logic       per_commit;
		logic       one_commit;
		logic       fin_commit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		op_t  op;
		logic scan_last;
		logic found;
		logic best_periodic;
		logic rem_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

>>> rtl/tqm_stream_if.sv
`default_nettype none
interface tqm_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/tqm_ctrl.sv
`default_nettype none
module tqm_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  tqm_pkg::sts_t     sts,
	output tqm_pkg::cmd_t     cmd
);

	tqm_pkg::state_t     state_q, state_d;
	tqm_pkg::scan_mode_t mode_q, mode_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tqm_pkg::ST_IDLE;
			mode_q  <= tqm_pkg::SCAN_DUE;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d       = state_q;
		mode_d        = mode_q;
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.scan_mode = mode_q;
		unique case (state_q)
			tqm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.item_load = 1'b1;
					state_d       = tqm_pkg::ST_DISPATCH;
				end
			end
			tqm_pkg::ST_DISPATCH: begin
				unique case (sts.op)
					tqm_pkg::OP_ADD: state_d = tqm_pkg::ST_ADD;
					tqm_pkg::OP_DEL: begin
						cmd.scan_start = 1'b1;
						mode_d         = tqm_pkg::SCAN_ID;
						state_d        = tqm_pkg::ST_SCAN;
					end
					tqm_pkg::OP_TICK: begin
						cmd.now_adv    = 1'b1;
						cmd.scan_start = 1'b1;
						mode_d         = tqm_pkg::SCAN_DUE;
						state_d        = tqm_pkg::ST_SCAN;
					end
					default: state_d = tqm_pkg::ST_IDLE;
				endcase
			end
			tqm_pkg::ST_ADD: begin
				if (sts.out_free) begin
					cmd.add_commit = 1'b1;
					state_d        = tqm_pkg::ST_IDLE;
				end
			end
			tqm_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					unique case (mode_q)
						tqm_pkg::SCAN_ID:  state_d = tqm_pkg::ST_DEL;
						tqm_pkg::SCAN_DUE: state_d = tqm_pkg::ST_DUE;
						default:           state_d = tqm_pkg::ST_FIN;
					endcase
				end
			end
			tqm_pkg::ST_DEL: begin
				if (sts.out_free) begin
					cmd.del_commit = 1'b1;
					state_d        = tqm_pkg::ST_IDLE;
				end
			end
			tqm_pkg::ST_DUE: begin
				if (!sts.found) begin
					cmd.scan_start = 1'b1;
					mode_d         = tqm_pkg::SCAN_ALL;
					state_d        = tqm_pkg::ST_SCAN;
				end else if (sts.best_periodic) begin
					cmd.rem_start = 1'b1;
					state_d       = tqm_pkg::ST_REM;
				end else begin
					state_d = tqm_pkg::ST_ONE;
				end
			end
			tqm_pkg::ST_REM: begin
				cmd.rem_step = 1'b1;
				if (sts.rem_last)
					state_d = tqm_pkg::ST_PER;
			end
			tqm_pkg::ST_PER: begin
				if (sts.out_free) begin
					cmd.per_commit = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = tqm_pkg::ST_SCAN;
				end
			end
			tqm_pkg::ST_ONE: begin
				if (sts.out_free) begin
					cmd.one_commit = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = tqm_pkg::ST_SCAN;
				end
			end
			tqm_pkg::ST_FIN: begin
				if (sts.out_free) begin
					cmd.fin_commit = 1'b1;
					state_d        = tqm_pkg::ST_IDLE;
				end
			end
			default: state_d = tqm_pkg::ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/tqm_datapath.sv
`default_nettype none
module tqm_datapath #(
	parameter int MAX_TIMERS = tqm_pkg::MAX_TIMERS_DEF,
	parameter int ID_WIDTH   = tqm_pkg::ID_WIDTH_DEF,
	parameter int TIME_WIDTH = tqm_pkg::TIME_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  tqm_pkg::tqm_in_t in_data,
	input  tqm_pkg::cmd_t    cmd,
	output tqm_pkg::sts_t    sts,
	tqm_stream_if.source     rsp
);

	localparam int IDX_W = $clog2(MAX_TIMERS);
	localparam int CNT_W = $clog2(MAX_TIMERS + 1);
	localparam int RC_W  = $clog2(TIME_WIDTH);

	tqm_pkg::tqm_in_t item_q;
	logic [TIME_WIDTH-1:0] now_q;
	logic [ID_WIDTH-1:0]   id_ctr_q;
	logic signed [31:0]    pend_q;
	logic [CNT_W-1:0]      live_q;
	logic [MAX_TIMERS-1:0] valid_q;

	logic [TIME_WIDTH-1:0] exp_q   [MAX_TIMERS];
	logic [30:0]           per_q   [MAX_TIMERS];
	logic [ID_WIDTH-1:0]   ident_q [MAX_TIMERS];
	logic [IDX_W-1:0]      ord_q   [MAX_TIMERS];

	// scan registers
	logic [IDX_W-1:0]      idx_q;
	logic                  found_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [TIME_WIDTH-1:0] best_exp_q;
	logic [IDX_W-1:0]      best_ord_q;
	logic [30:0]           best_per_q;
	logic [ID_WIDTH-1:0]   best_id_q;

	// remainder unit
	logic [TIME_WIDTH-1:0] dvd_q;
	logic [31:0]           rem_q;
	logic [RC_W-1:0]       rcnt_q;
	logic [31:0]           trial;
	logic [TIME_WIDTH-1:0] per_next;

	logic                  out_valid_q;
	tqm_pkg::tqm_out_t     out_q;

	logic                  cand_ok, better, take, full, out_free, do_free;
	logic [IDX_W-1:0]      free_idx;
	logic [ID_WIDTH-1:0]   id_use;
	logic signed [31:0]    add_pend;
	logic [TIME_WIDTH-1:0] fin_diff;
	logic signed [31:0]    fin_wait;

	// candidate test for the slot under the scan pointer
	always_comb begin
		case (cmd.scan_mode)
			tqm_pkg::SCAN_DUE: cand_ok = valid_q[idx_q] && (exp_q[idx_q] <= now_q);
			tqm_pkg::SCAN_ALL: cand_ok = valid_q[idx_q];
			default: cand_ok = valid_q[idx_q] &&
				(32'(ident_q[idx_q]) == 32'(item_q.target_id));
		endcase
		better = !found_q || ((cmd.scan_mode != tqm_pkg::SCAN_ID) &&
			((exp_q[idx_q] < best_exp_q) ||
			 ((exp_q[idx_q] == best_exp_q) && (ord_q[idx_q] < best_ord_q))));
		take = cmd.scan_step && cand_ok && better;
	end

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = MAX_TIMERS - 1; i >= 0; i--)
			if (!valid_q[i])
				free_idx = IDX_W'(i);
	end

	assign full     = live_q >= CNT_W'(MAX_TIMERS);
	assign out_free = !out_valid_q || rsp.ready;
	assign id_use   = (id_ctr_q == '0) ? ID_WIDTH'(1) : id_ctr_q;
	assign add_pend = ((pend_q < 0) || (pend_q > $signed({1'b0, item_q.delay_ms}))) ?
		$signed({1'b0, item_q.delay_ms}) : pend_q;
	assign fin_diff = best_exp_q - now_q;
	assign fin_wait = !found_q ? tqm_pkg::WAIT_NONE :
		(fin_diff > TIME_WIDTH'(tqm_pkg::WAIT_MAX)) ? $signed(tqm_pkg::WAIT_MAX) :
		$signed(fin_diff[31:0]);
	assign do_free  = cmd.one_commit || (cmd.del_commit && found_q);

	// restoring remainder step and the stepped expiry
	assign trial    = {rem_q[30:0], dvd_q[TIME_WIDTH-1]};
	assign per_next = now_q - TIME_WIDTH'(rem_q) + TIME_WIDTH'(best_per_q);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			id_ctr_q    <= ID_WIDTH'(1);
			pend_q      <= tqm_pkg::WAIT_NONE;
			live_q      <= '0;
			valid_q     <= '0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			rcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.now_adv)
				now_q <= now_q + TIME_WIDTH'(item_q.elapsed_ms);
			if (cmd.scan_start) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan_step) begin
				idx_q <= idx_q + IDX_W'(1);
				if (take)
					found_q <= 1'b1;
			end
			if (cmd.rem_start)
				rcnt_q <= '0;
			else if (cmd.rem_step)
				rcnt_q <= rcnt_q + RC_W'(1);
			if (cmd.add_commit && !full) begin
				id_ctr_q          <= id_use + ID_WIDTH'(1);
				valid_q[free_idx] <= 1'b1;
				live_q            <= live_q + CNT_W'(1);
				pend_q            <= add_pend;
			end
			if (do_free) begin
				valid_q[best_idx_q] <= 1'b0;
				if (live_q != '0)
					live_q <= live_q - CNT_W'(1);
			end
			if (cmd.fin_commit)
				pend_q <= fin_wait;
			if (cmd.add_commit || cmd.del_commit || cmd.per_commit ||
			    cmd.one_commit || cmd.fin_commit)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	// slot table, scan capture, remainder and result payload
	always_ff @(posedge clk) begin
		if (cmd.item_load)
			item_q <= in_data;
		if (take) begin
			best_idx_q <= idx_q;
			best_exp_q <= exp_q[idx_q];
			best_ord_q <= ord_q[idx_q];
			best_per_q <= per_q[idx_q];
			best_id_q  <= ident_q[idx_q];
		end
		if (cmd.rem_start) begin
			dvd_q <= now_q - best_exp_q;
			rem_q <= '0;
		end else if (cmd.rem_step) begin
			dvd_q <= {dvd_q[TIME_WIDTH-2:0], 1'b0};
			rem_q <= (trial >= {1'b0, best_per_q}) ? trial - {1'b0, best_per_q} : trial;
		end
		if (cmd.add_commit && !full) begin
			exp_q[free_idx]   <= now_q + TIME_WIDTH'(item_q.delay_ms);
			per_q[free_idx]   <= item_q.periodic ? item_q.delay_ms : '0;
			ident_q[free_idx] <= id_use;
			ord_q[free_idx]   <= IDX_W'(live_q);
		end
		if (cmd.per_commit)
			exp_q[best_idx_q] <= per_next;
		// close the add-order gap left by a freed slot
		if (do_free) begin
			for (int j = 0; j < MAX_TIMERS; j++)
				if (valid_q[j] && (IDX_W'(j) != best_idx_q) && (ord_q[j] > best_ord_q))
					ord_q[j] <= ord_q[j] - IDX_W'(1);
		end
		if (cmd.add_commit) begin
			out_q.kind        <= full ? tqm_pkg::KIND_FULL : tqm_pkg::KIND_ADDED;
			out_q.tmr_id      <= full ? 16'd0 : 16'(id_use);
			out_q.is_periodic <= 1'b0;
			out_q.next_wait   <= full ? pend_q : add_pend;
			out_q.last        <= 1'b1;
		end else if (cmd.del_commit) begin
			out_q.kind        <= found_q ? tqm_pkg::KIND_DELETED : tqm_pkg::KIND_NOT_FOUND;
			out_q.tmr_id      <= found_q ? item_q.target_id : 16'd0;
			out_q.is_periodic <= 1'b0;
			out_q.next_wait   <= pend_q;
			out_q.last        <= 1'b1;
		end else if (cmd.per_commit || cmd.one_commit) begin
			out_q.kind        <= tqm_pkg::KIND_EXPIRED;
			out_q.tmr_id      <= 16'(best_id_q);
			out_q.is_periodic <= cmd.per_commit;
			out_q.next_wait   <= '0;
			out_q.last        <= 1'b0;
		end else if (cmd.fin_commit) begin
			out_q.kind        <= tqm_pkg::KIND_TICK_DONE;
			out_q.tmr_id      <= 16'd0;
			out_q.is_periodic <= 1'b0;
			out_q.next_wait   <= fin_wait;
			out_q.last        <= 1'b1;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	assign sts.op            = tqm_pkg::op_t'(item_q.opcode);
	assign sts.scan_last     = idx_q == IDX_W'(MAX_TIMERS - 1);
	assign sts.found         = found_q;
	assign sts.best_periodic = best_per_q != '0;
	assign sts.rem_last      = rcnt_q == RC_W'(TIME_WIDTH - 1);
	assign sts.out_free      = out_free;

endmodule
`default_nettype wire

>>> rtl/timer_queue_manager_top.sv
// Timer queue manager: a table of MAX_TIMERS timers with its own millisecond
// clock. Items come in on req (add, delete, tick); results leave on rsp. A
// transfer takes place on a clock edge with valid and ready both high.
// One item is worked on at a time; req.ready is high only while idle.
// An add needs no table scan; a delete is set by a scan of the table, one
// slot per cycle. A tick scans the table once per expired timer and twice
// for the closing result (a due scan that finds nothing, then a full scan
// for the earliest expiry); a periodic timer adds a bit-serial remainder step.
// Every item but opcode 3 gives results ending with one marked last; a tick
// gives one expired result per due timer in expiry order, then tick done.
// Results sit in an output register; when rsp is stalled the block holds
// the result and waits before producing the next one, losing nothing.
// Reset (arst_n low) empties the table, zeroes the clock, sets the id
// counter to 1 and the reported wait to -1; no clearing pass is needed.
`default_nettype none
module timer_queue_manager_top #(
	parameter int MAX_TIMERS = tqm_pkg::MAX_TIMERS_DEF,
	parameter int ID_WIDTH   = tqm_pkg::ID_WIDTH_DEF,
	parameter int TIME_WIDTH = tqm_pkg::TIME_WIDTH_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	tqm_stream_if.sink   req,
	tqm_stream_if.source rsp
);

	tqm_pkg::cmd_t cmd;
	tqm_pkg::sts_t sts;

	tqm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tqm_datapath #(
		.MAX_TIMERS (MAX_TIMERS),
		.ID_WIDTH   (ID_WIDTH),
		.TIME_WIDTH (TIME_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_data (req.data),
		.cmd     (cmd),
		.sts     (sts),
		.rsp     (rsp)
	);

endmodule
`default_nettype wire

>>> rtl/tqm_checker.sv
`default_nettype none
module tqm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [2:0]  rsp_kind,
	input wire logic [15:0] rsp_id,
	input wire logic [31:0] rsp_wait,
	input wire logic        rsp_last
);

	// one item at a time: busy right after a transfer in
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("input taken while busy");

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
			$stable(rsp_id) && $stable(rsp_wait) && $stable(rsp_last))
		else $error("stalled result changed");

	// expired results are never last and carry no wait
	a_expired_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_kind == tqm_pkg::KIND_EXPIRED) |-> !rsp_last && (rsp_wait == '0))
		else $error("bad expired result");

	// every other result closes its item
	a_close_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_kind != tqm_pkg::KIND_EXPIRED) |-> rsp_last)
		else $error("closing result not last");

	// results without a timer carry id zero
	a_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((rsp_kind == tqm_pkg::KIND_FULL) ||
			(rsp_kind == tqm_pkg::KIND_NOT_FOUND) ||
			(rsp_kind == tqm_pkg::KIND_TICK_DONE)) |-> (rsp_id == '0))
		else $error("nonzero id");

endmodule

bind timer_queue_manager_top tqm_checker u_tqm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_kind  (rsp.data.kind),
	.rsp_id    (rsp.data.tmr_id),
	.rsp_wait  (rsp.data.next_wait),
	.rsp_last  (rsp.data.last)
);
`default_nettype wire
